@@ hw/rtl/sis_pkg.sv @@
// Shared types and constants for the sorted interval set insert core.
`timescale 1ns / 1ps

package sis_pkg;

    localparam int MAX_RANGES_DEF = 64;
    localparam int LINE_W         = 31;
    localparam int OP_W           = 2;
    localparam int IDX_OUT_W      = 6;
    localparam int CNT_OUT_W      = 7;
    localparam int STATUS_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_ORDER     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef struct packed {
        logic [LINE_W-1:0] line_lo;
        logic [LINE_W-1:0] line_hi;
    } t_range;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_range   load;
    } t_cell_ctrl;

    typedef struct packed {
        logic below;
        logic hit;
    } t_cell_flags;

endpackage

@@ hw/rtl/sorted_interval_set_insert_core.sv @@
// Top level: sorted interval set with coalescing insert, read and clear over a chain of cells.
// A result is registered after its transaction passes the compare and evaluate states; a new
// transaction can be taken in the evaluate step as that result commits. An insert that coalesces
// two or more stored ranges instead shifts the cell chain one slot per cycle, then idles, input held off.
// A full output register holds the evaluate step until the result is taken.
// Reset clears the count and control state; stored entries stay undefined, with no clearing pass.
`timescale 1ns / 1ps

module sorted_interval_set_insert_core #(
    parameter int MAX_RANGES = sis_pkg::MAX_RANGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sis_pkg::OP_W-1:0]       i_op,
    input  logic [sis_pkg::LINE_W-1:0]     i_range_start,
    input  logic [sis_pkg::LINE_W-1:0]     i_range_end,
    input  logic [sis_pkg::IDX_OUT_W-1:0]  i_entry_index,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [sis_pkg::LINE_W-1:0]     o_out_start,
    output logic [sis_pkg::LINE_W-1:0]     o_out_end,
    output logic [sis_pkg::IDX_OUT_W-1:0]  o_out_index,
    output logic [sis_pkg::CNT_OUT_W-1:0]  o_range_count,
    output logic [sis_pkg::STATUS_W-1:0]   o_status
);
    import sis_pkg::*;

    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EVAL,
        S_SHIFT
    } t_state;

    t_state                 r_state, n_state;
    logic [OP_W-1:0]        r_op, n_op;
    t_range                 r_req, n_req;
    logic [IDX_OUT_W-1:0]   r_idx, n_idx;
    logic [CW-1:0]          r_count, n_count;
    logic [MAX_RANGES-1:0]  r_below, n_below;
    logic [MAX_RANGES-1:0]  r_hit, n_hit;
    logic [CW-1:0]          r_shift, n_shift;
    logic [CW-1:0]          r_lo, n_lo;
    logic                   r_out_valid, n_out_valid;
    logic [LINE_W-1:0]      r_out_start, n_out_start;
    logic [LINE_W-1:0]      r_out_end, n_out_end;
    logic [IDX_OUT_W-1:0]   r_out_index, n_out_index;
    logic [CNT_OUT_W-1:0]   r_out_count, n_out_count;
    logic [STATUS_W-1:0]    r_out_status, n_out_status;

    t_range                 w_range [MAX_RANGES];
    t_cell_flags            w_flags [MAX_RANGES];
    t_cell_ctrl             w_ctrl  [MAX_RANGES];
    logic [MAX_RANGES-1:0]  w_below;
    logic [MAX_RANGES-1:0]  w_hit;
    logic [MAX_RANGES-1:0]  w_span;

    logic                   w_accept;
    logic                   w_can_commit;
    logic                   w_need_shift;
    logic                   w_any_hit;
    logic [CW-1:0]          w_lo;
    logic [CW-1:0]          w_hi;
    logic [CW-1:0]          w_hits;
    logic [LINE_W-1:0]      w_first_lo;
    logic [LINE_W-1:0]      w_last_hi;
    logic [LINE_W-1:0]      w_rd_lo;
    logic [LINE_W-1:0]      w_rd_hi;
    t_range                 w_load;
    logic                   w_ins_ok;
    logic [LINE_W-1:0]      w_res_start;
    logic [LINE_W-1:0]      w_res_end;
    logic [IDX_OUT_W-1:0]   w_res_index;
    logic [CW-1:0]          w_res_count;
    logic [STATUS_W-1:0]    w_res_status;

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        t_range w_left;
        t_range w_right;
        if (g == 0) begin : g_first
            assign w_left = w_range[g];
        end else begin : g_mid_l
            assign w_left = w_range[g-1];
        end
        if (g == MAX_RANGES - 1) begin : g_last
            assign w_right = w_range[g];
        end else begin : g_mid_r
            assign w_right = w_range[g+1];
        end

        sis_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_req   (r_req),
            .i_valid (r_count > CW'(g)),
            .o_range (w_range[g]),
            .o_flags (w_flags[g])
        );

        assign w_below[g] = w_flags[g].below;
        assign w_hit[g]   = w_flags[g].hit;
    end

    assign w_span = r_below | r_hit;

    always_comb begin
        logic [MAX_RANGES:0] below_x;
        logic [MAX_RANGES:0] span_x;
        logic [MAX_RANGES:0] hit_x;
        logic [MAX_RANGES:0] hit_p;
        below_x    = {1'b0, r_below};
        span_x     = {1'b0, w_span};
        hit_x      = {1'b0, r_hit};
        hit_p      = {r_hit, 1'b0};
        w_lo       = '0;
        w_hi       = '0;
        w_first_lo = '0;
        w_last_hi  = '0;
        w_rd_lo    = '0;
        w_rd_hi    = '0;
        for (int i = 0; i < MAX_RANGES; i++) begin
            if (below_x[i] && !below_x[i+1]) begin
                w_lo = w_lo | CW'(i + 1);
            end
            if (span_x[i] && !span_x[i+1]) begin
                w_hi = w_hi | CW'(i + 1);
            end
            if (r_hit[i] && !hit_p[i]) begin
                w_first_lo = w_first_lo | w_range[i].line_lo;
            end
            if (r_hit[i] && !hit_x[i+1]) begin
                w_last_hi = w_last_hi | w_range[i].line_hi;
            end
            if (int'(r_idx) == i) begin
                w_rd_lo = w_rd_lo | w_range[i].line_lo;
                w_rd_hi = w_rd_hi | w_range[i].line_hi;
            end
        end
    end

    assign w_any_hit = |r_hit;
    assign w_hits    = w_hi - w_lo;

    always_comb begin
        w_load.line_lo = r_req.line_lo;
        w_load.line_hi = r_req.line_hi;
        if (w_any_hit) begin
            w_load.line_lo = (w_first_lo < r_req.line_lo) ? w_first_lo : r_req.line_lo;
            w_load.line_hi = (w_last_hi > r_req.line_hi) ? w_last_hi : r_req.line_hi;
        end
    end

    always_comb begin
        w_ins_ok     = 1'b0;
        w_res_start  = '0;
        w_res_end    = '0;
        w_res_index  = '0;
        w_res_count  = r_count;
        w_res_status = ST_OK;
        unique case (r_op)
            OP_INSERT: begin
                if (r_req.line_lo > r_req.line_hi) begin
                    w_res_status = ST_ORDER;
                end else if (!w_any_hit && (r_count == CW'(MAX_RANGES))) begin
                    w_res_status = ST_FULL;
                end else begin
                    w_ins_ok    = 1'b1;
                    w_res_start = w_load.line_lo;
                    w_res_end   = w_load.line_hi;
                    w_res_index = IDX_OUT_W'(w_lo);
                    w_res_count = w_any_hit ? (r_count - w_hits + CW'(1)) : (r_count + CW'(1));
                end
            end
            OP_READ: begin
                if (int'(r_idx) < int'(r_count)) begin
                    w_res_start = w_rd_lo;
                    w_res_end   = w_rd_hi;
                    w_res_index = r_idx;
                end else begin
                    w_res_status = ST_BAD_INDEX;
                end
            end
            OP_CLEAR: begin
                w_res_count = '0;
            end
            default: begin
                w_res_count = r_count;
            end
        endcase
    end

    assign w_can_commit = !r_out_valid || i_out_ready;
    assign w_need_shift = w_ins_ok && w_any_hit && (w_hits > CW'(1));
    assign o_in_ready   = (r_state == S_IDLE) ||
                          ((r_state == S_EVAL) && w_can_commit && !w_need_shift);
    assign w_accept     = i_in_valid && o_in_ready;

    always_comb begin
        for (int i = 0; i < MAX_RANGES; i++) begin
            w_ctrl[i].op   = CELL_HOLD;
            w_ctrl[i].load = w_load;
            if ((r_state == S_EVAL) && w_can_commit && w_ins_ok) begin
                if (CW'(i) == w_lo) begin
                    w_ctrl[i].op = CELL_LOAD;
                end else if (!w_any_hit && (CW'(i) > w_lo)) begin
                    w_ctrl[i].op = CELL_TAKE_LEFT;
                end
            end
            if ((r_state == S_SHIFT) && (CW'(i) > r_lo)) begin
                w_ctrl[i].op = CELL_TAKE_RIGHT;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_req        = r_req;
        n_idx        = r_idx;
        n_count      = r_count;
        n_below      = r_below;
        n_hit        = r_hit;
        n_shift      = r_shift;
        n_lo         = r_lo;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_start  = r_out_start;
        n_out_end    = r_out_end;
        n_out_index  = r_out_index;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_below = w_below;
                n_hit   = w_hit;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_can_commit) begin
                    n_out_valid  = 1'b1;
                    n_out_start  = w_res_start;
                    n_out_end    = w_res_end;
                    n_out_index  = w_res_index;
                    n_out_count  = CNT_OUT_W'(w_res_count);
                    n_out_status = w_res_status;
                    n_count      = w_res_count;
                    if (w_need_shift) begin
                        n_shift = w_hits - CW'(1);
                        n_lo    = w_lo;
                        n_state = S_SHIFT;
                    end else if (w_accept) begin
                        n_state = S_CMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                n_shift = r_shift - CW'(1);
                if (r_shift == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_accept) begin
            n_op          = i_op;
            n_req.line_lo = i_range_start;
            n_req.line_hi = i_range_end;
            n_idx         = i_entry_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_shift     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_shift     <= n_shift;
        end
        r_op         <= n_op;
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_below      <= n_below;
        r_hit        <= n_hit;
        r_lo         <= n_lo;
        r_out_start  <= n_out_start;
        r_out_end    <= n_out_end;
        r_out_index  <= n_out_index;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_start   = r_out_start;
    assign o_out_end     = r_out_end;
    assign o_out_index   = r_out_index;
    assign o_range_count = r_out_count;
    assign o_status      = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RANGES))
        else $error("stored count above table depth");

    a_flags_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ((r_below & r_hit) == '0))
        else $error("cell both below and overlapping");

    a_below_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (((r_below + 1'b1) & r_below) == '0))
        else $error("below flags not a prefix of the table");

    a_span_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (((w_span + 1'b1) & w_span) == '0))
        else $error("overlapping run not contiguous");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && w_can_commit && w_res_status == ST_FULL)
            |=> (r_count == CW'(MAX_RANGES)))
        else $error("full status with room in the table");

endmodule

@@ hw/rtl/sis_cell.sv @@
// One table slot: holds a stored range, compares it with the request, shifts with neighbors.
`timescale 1ns / 1ps

module sis_cell (
    input  logic                 i_clk,
    input  sis_pkg::t_cell_ctrl  i_ctrl,
    input  sis_pkg::t_range      i_left,
    input  sis_pkg::t_range      i_right,
    input  sis_pkg::t_range      i_req,
    input  logic                 i_valid,
    output sis_pkg::t_range      o_range,
    output sis_pkg::t_cell_flags o_flags
);
    import sis_pkg::*;

    t_range            r_range;
    logic [LINE_W:0]   w_hi_next;
    logic [LINE_W:0]   w_req_hi_next;
    logic              w_below;

    assign w_hi_next     = {1'b0, r_range.line_hi} + {{LINE_W{1'b0}}, 1'b1};
    assign w_req_hi_next = {1'b0, i_req.line_hi} + {{LINE_W{1'b0}}, 1'b1};
    assign w_below       = i_valid && (w_hi_next < {1'b0, i_req.line_lo});

    assign o_flags.below = w_below;
    assign o_flags.hit   = i_valid && !w_below && ({1'b0, r_range.line_lo} <= w_req_hi_next);
    assign o_range       = r_range;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            CELL_LOAD:       r_range <= i_ctrl.load;
            CELL_TAKE_LEFT:  r_range <= i_left;
            CELL_TAKE_RIGHT: r_range <= i_right;
            default:         r_range <= r_range;
        endcase
    end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the sorted interval set insert core.
`timescale 1ns / 1ps

module tb;

    import sis_pkg::*;

    localparam int                TBL_DEPTH   = MAX_RANGES_DEF;
    localparam int                RANDOM_ITEMS = 1100;
    localparam logic [LINE_W-1:0] LINE_MAX    = '1;
    localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;

    typedef enum int {
        FILL_GRID,
        FILL_DENSE,
        FILL_NOISE
    } t_fill;

    typedef struct packed {
        logic [LINE_W-1:0]    lo;
        logic [LINE_W-1:0]    hi;
        logic [IDX_OUT_W-1:0] slot;
        logic [CNT_OUT_W-1:0] count;
        logic [STATUS_W-1:0]  status;
    } t_line_result;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [LINE_W-1:0]    first;
        logic [LINE_W-1:0]    last;
        logic [IDX_OUT_W-1:0] slot;
        bit                   typed;
        t_line_result         want;
    } t_dir_row;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [OP_W-1:0]      i_op          = OP_INSERT;
    logic [LINE_W-1:0]    i_range_start = '0;
    logic [LINE_W-1:0]    i_range_end   = '0;
    logic [IDX_OUT_W-1:0] i_entry_index = '0;
    logic                 i_out_ready   = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [LINE_W-1:0]    o_out_start;
    logic [LINE_W-1:0]    o_out_end;
    logic [IDX_OUT_W-1:0] o_out_index;
    logic [CNT_OUT_W-1:0] o_range_count;
    logic [STATUS_W-1:0]  o_status;

    logic [LINE_W-1:0] span_lo [TBL_DEPTH];
    logic [LINE_W-1:0] span_hi [TBL_DEPTH];
    int                span_count = 0;

    t_line_result expected_results[$];
    t_dir_row     directed_rows[$];
    int           errors      = 0;
    int           burst_left  = 4;
    int           ready_mode  = 0;
    int           ready_hold  = 0;
    logic [12:0]  ready_pattern = 13'b1011001110100;

    sorted_interval_set_insert_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .i_entry_index (i_entry_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_start   (o_out_start),
        .o_out_end     (o_out_end),
        .o_out_index   (o_out_index),
        .o_range_count (o_range_count),
        .o_status      (o_status)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_line_result line_result(logic [LINE_W-1:0] lo, logic [LINE_W-1:0] hi,
                                                 logic [IDX_OUT_W-1:0] slot,
                                                 logic [CNT_OUT_W-1:0] count,
                                                 logic [STATUS_W-1:0] status);
        t_line_result r;
        r.lo     = lo;
        r.hi     = hi;
        r.slot   = slot;
        r.count  = count;
        r.status = status;
        return r;
    endfunction

    function automatic t_line_result coalesce_step(logic [OP_W-1:0] op, logic [LINE_W-1:0] s,
                                                   logic [LINE_W-1:0] e,
                                                   logic [IDX_OUT_W-1:0] idx);
        t_line_result      r;
        int                lo;
        int                hi;
        int                k;
        int                gone;
        logic [LINE_W-1:0] ms;
        logic [LINE_W-1:0] me;
        r  = '0;
        ms = s;
        me = e;
        case (op)
            OP_INSERT: begin
                if (s > e) begin
                    r.status = ST_ORDER;
                end else begin
                    lo = 0;
                    while (lo < span_count && {1'b0, span_hi[lo]} + 32'd1 < {1'b0, s})
                        lo++;
                    hi = lo;
                    while (hi < span_count && {1'b0, span_lo[hi]} <= {1'b0, e} + 32'd1)
                        hi++;
                    if (hi == lo && span_count >= TBL_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        if (hi == lo) begin
                            for (k = span_count; k > lo; k--) begin
                                span_lo[k] = span_lo[k-1];
                                span_hi[k] = span_hi[k-1];
                            end
                            span_count++;
                        end else begin
                            if (span_lo[lo] < ms) ms = span_lo[lo];
                            if (span_hi[hi-1] > me) me = span_hi[hi-1];
                            gone = hi - lo - 1;
                            if (gone > 0) begin
                                for (k = lo + 1; k + gone < span_count; k++) begin
                                    span_lo[k] = span_lo[k+gone];
                                    span_hi[k] = span_hi[k+gone];
                                end
                                span_count -= gone;
                            end
                        end
                        span_lo[lo] = ms;
                        span_hi[lo] = me;
                        r.lo     = ms;
                        r.hi     = me;
                        r.slot   = IDX_OUT_W'(lo);
                        r.status = ST_OK;
                    end
                end
            end
            OP_READ: begin
                if (idx < span_count) begin
                    r.lo     = span_lo[idx];
                    r.hi     = span_hi[idx];
                    r.slot   = idx;
                    r.status = ST_OK;
                end else begin
                    r.status = ST_BAD_INDEX;
                end
            end
            OP_CLEAR: span_count = 0;
            default: r.status = ST_OK;
        endcase
        r.count = CNT_OUT_W'(span_count);
        return r;
    endfunction

    task automatic send_transaction(logic [OP_W-1:0] op, logic [LINE_W-1:0] s,
                                    logic [LINE_W-1:0] e, logic [IDX_OUT_W-1:0] idx,
                                    bit typed, t_line_result want);
        t_line_result predicted;
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_range_start <= s;
        i_range_end   <= e;
        i_entry_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = coalesce_step(op, s, e, idx);
        expected_results.push_back(typed ? want : predicted);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_line_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected transaction: expected none actual %0h %0h %0h %0h %0h",
                         $time, o_out_start, o_out_end, o_out_index, o_range_count, o_status);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("out_start", 32'(want.lo), 32'(o_out_start));
                check_field("out_end", 32'(want.hi), 32'(o_out_end));
                check_field("out_index", 32'(want.slot), 32'(o_out_index));
                check_field("range_count", 32'(want.count), 32'(o_range_count));
                check_field("status", 32'(want.status), 32'(o_status));
            end
        end
        if (ready_hold == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(8, 80);
        end else begin
            ready_hold--;
        end
        case (ready_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 9) < 7);
            2: begin
                ready_pattern = {ready_pattern[11:0], ready_pattern[12]};
                i_out_ready   <= ready_pattern[0];
            end
            default: i_out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    initial begin
        #4ms;
        $display("tb: errors");
        $finish;
    end

    initial begin
        t_dir_row          row;
        t_fill             fill;
        logic [LINE_W-1:0] base;
        logic [LINE_W-1:0] s;
        logic [LINE_W-1:0] e;
        logic [LINE_W-1:0] t;
        logic [OP_W-1:0]   op;
        logic [IDX_OUT_W-1:0] idx;
        int                sent;
        int                episode_len;
        int                pick;
        int                k;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_rows = '{
            '{OP_READ,   '0, '0, '0, 1'b1, line_result('0, '0, '0, 7'd0, ST_BAD_INDEX)},
            '{OP_UNUSED, LINE_MAX, LINE_MAX, '1, 1'b1, line_result('0, '0, '0, 7'd0, ST_OK)},
            '{OP_INSERT, 31'd5, 31'd4, '0, 1'b1, line_result('0, '0, '0, 7'd0, ST_ORDER)},
            '{OP_INSERT, 31'd0, 31'd0, '0, 1'b1, line_result('0, '0, '0, 7'd1, ST_OK)},
            '{OP_INSERT, LINE_MAX, LINE_MAX, '0, 1'b1,
              line_result(LINE_MAX, LINE_MAX, 6'd1, 7'd2, ST_OK)},
            '{OP_INSERT, 31'd2, 31'd3, '0, 1'b0, '0},
            '{OP_INSERT, 31'd1, 31'd1, '0, 1'b0, '0},
            '{OP_INSERT, 31'd10, 31'd19, '0, 1'b0, '0},
            '{OP_INSERT, 31'd30, 31'd40, '0, 1'b0, '0},
            '{OP_INSERT, 31'd21, 31'd28, '0, 1'b0, '0},
            '{OP_INSERT, 31'd20, 31'd29, '0, 1'b0, '0},
            '{OP_INSERT, 31'd15, 31'd12, '0, 1'b0, '0},
            '{OP_READ,   '0, '0, 6'd1, 1'b0, '0},
            '{OP_READ,   '0, '0, 6'd63, 1'b0, '0},
            '{OP_INSERT, LINE_MAX - 31'd1, LINE_MAX - 31'd1, '0, 1'b0, '0},
            '{OP_INSERT, 31'd0, LINE_MAX, '0, 1'b1,
              line_result('0, LINE_MAX, '0, 7'd1, ST_OK)},
            '{OP_READ,   '0, '0, '0, 1'b1, line_result('0, LINE_MAX, '0, 7'd1, ST_OK)},
            '{OP_CLEAR,  '0, '0, '0, 1'b1, line_result('0, '0, '0, 7'd0, ST_OK)},
            '{OP_READ,   '0, '0, '0, 1'b1, line_result('0, '0, '0, 7'd0, ST_BAD_INDEX)},
            '{OP_INSERT, LINE_MAX, 31'd0, '0, 1'b1, line_result('0, '0, '0, 7'd0, ST_ORDER)},
            '{OP_INSERT, 31'h2AAA_AAAA, 31'h5555_5555, '0, 1'b0, '0},
            '{OP_INSERT, 31'd41, 31'h2AAA_AAA9, '0, 1'b0, '0},
            '{OP_READ,   '0, '0, 6'd42, 1'b0, '0},
            '{OP_READ,   '0, '0, 6'd21, 1'b0, '0},
            '{OP_CLEAR,  '0, '0, '0, 1'b1, line_result('0, '0, '0, 7'd0, ST_OK)}
        };
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_transaction(row.op, row.first, row.last, row.slot, row.typed, row.want);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            fill = (pick < 4) ? FILL_GRID : (pick < 8) ? FILL_DENSE : FILL_NOISE;
            case ($urandom_range(0, 3))
                0: base = '0;
                1: base = LINE_MAX - 31'd1000;
                default: base = LINE_W'($urandom_range(0, 32'(LINE_MAX) - 1000));
            endcase
            episode_len = (fill == FILL_GRID) ? $urandom_range(80, 140)
                                              : $urandom_range(30, 100);
            for (k = 0; k < episode_len; k++) begin
                op   = OP_INSERT;
                idx  = '0;
                pick = $urandom_range(0, 99);
                if (fill == FILL_NOISE) pick = pick % 16;
                if (pick < 8) begin
                    op  = OP_READ;
                    idx = (span_count > 0 && $urandom_range(0, 3) != 0)
                          ? IDX_OUT_W'($urandom_range(0, span_count - 1))
                          : IDX_OUT_W'($urandom_range(0, TBL_DEPTH - 1));
                    s   = LINE_W'($urandom);
                    e   = LINE_W'($urandom);
                end else if (pick < 10) begin
                    op  = ($urandom_range(0, 1) == 0) ? OP_UNUSED : OP_INSERT;
                    s   = LINE_W'($urandom);
                    e   = LINE_W'($urandom);
                    idx = IDX_OUT_W'($urandom);
                    if (s == e) s = s + 31'd1;
                    if (s < e) begin
                        t = s;
                        s = e;
                        e = t;
                    end
                end else if (pick < 12) begin
                    s = LINE_W'($urandom);
                    e = LINE_W'($urandom);
                    if (s > e && $urandom_range(0, 1) == 0) begin
                        t = s;
                        s = e;
                        e = t;
                    end
                end else if (pick == 12) begin
                    op = OP_CLEAR;
                    s  = LINE_W'($urandom);
                    e  = LINE_W'($urandom);
                end else if (pick < 15) begin
                    s = base + LINE_W'($urandom_range(0, 200));
                    e = s + LINE_W'($urandom_range(0, 400));
                end else if (fill == FILL_GRID) begin
                    s = base + LINE_W'(4 * $urandom_range(0, 99));
                    e = s + LINE_W'($urandom_range(0, 1));
                    if ($urandom_range(0, 19) == 0) begin
                        s = s + 31'd2;
                        e = s;
                    end
                end else begin
                    s = base + LINE_W'($urandom_range(0, 600));
                    e = s + LINE_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                                 : $urandom_range(0, 40));
                end
                send_transaction(op, s, e, idx, 1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 1) == 0) begin
                send_transaction(OP_CLEAR, LINE_W'($urandom), LINE_W'($urandom),
                                 IDX_OUT_W'($urandom), 1'b0, '0);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
